[src/rpb_pkg.sv]
// Shared constants, codes and control/status types for the root pairing block.
`timescale 1ns / 1ps
package rpb_pkg;

    localparam int MAX_ROOTS = 32;
    localparam int FRAC_BITS = 20;
    localparam int TOL_BITS  = 20;
    localparam int ROOT_W    = 24;
    localparam int COEF_W    = 32;
    localparam int IDX_W     = 5;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 20'd210;

    typedef enum logic [1:0] {
        CMD_LOAD_ZERO = 2'd0,
        CMD_LOAD_POLE = 2'd1,
        CMD_COMPUTE   = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEXT_I,
        S_LOAD_I,
        S_TOL,
        S_SCAN,
        S_CHK,
        S_MUL,
        S_WR,
        S_ERD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic next_set;
        logic finish;
        logic i_inc;
        logic take_i;
        logic latch_i;
        logic tol;
        logic j_inc;
        logic rd_j;
        logic take_j;
        logic alone;
        logic drop;
        logic mul;
        logic wr_sec;
        logic emit_rd;
        logic emit_out;
    } ctl_t;

    typedef struct packed {
        logic i_end;
        logic i_taken;
        logic j_end;
        logic j_taken;
        logic q_nz;
        logic match;
        logic set_pole;
        logic last;
    } sts_t;

endpackage

[src/rpb_ctrl.sv]
// Sequencer for loads, root pairing walk and section emission.
`timescale 1ns / 1ps
module rpb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    cmd,
    input  rpb_pkg::sts_t sts,
    output rpb_pkg::ctl_t ctl,
    output logic          busy
);

    rpb_pkg::state_t state_reg;
    rpb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            rpb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (rpb_pkg::cmd_t'(cmd)) inside
                        rpb_pkg::CMD_LOAD_ZERO, rpb_pkg::CMD_LOAD_POLE: ctl.load = 1'b1;
                        rpb_pkg::CMD_CLEAR: ctl.clear = 1'b1;
                        rpb_pkg::CMD_COMPUTE:
                        begin
                            ctl.start  = 1'b1;
                            state_next = rpb_pkg::S_NEXT_I;
                        end
                        default: ;
                    endcase
                end
            end
            rpb_pkg::S_NEXT_I:
            begin
                if (sts.i_end)
                begin
                    if (sts.set_pole)
                    begin
                        ctl.finish = 1'b1;
                        state_next = rpb_pkg::S_ERD;
                    end
                    else
                    begin
                        ctl.next_set = 1'b1;
                    end
                end
                else if (sts.i_taken)
                begin
                    ctl.i_inc = 1'b1;
                end
                else
                begin
                    ctl.take_i = 1'b1;
                    state_next = rpb_pkg::S_LOAD_I;
                end
            end
            rpb_pkg::S_LOAD_I:
            begin
                ctl.latch_i = 1'b1;
                state_next  = rpb_pkg::S_TOL;
            end
            rpb_pkg::S_TOL:
            begin
                ctl.tol    = 1'b1;
                state_next = rpb_pkg::S_SCAN;
            end
            rpb_pkg::S_SCAN:
            begin
                if (sts.j_end)
                begin
                    if (sts.q_nz)
                    begin
                        // drop an unmatched complex root
                        ctl.drop   = 1'b1;
                        ctl.i_inc  = 1'b1;
                        state_next = rpb_pkg::S_NEXT_I;
                    end
                    else
                    begin
                        ctl.alone  = 1'b1;
                        state_next = rpb_pkg::S_MUL;
                    end
                end
                else if (sts.j_taken)
                begin
                    ctl.j_inc = 1'b1;
                end
                else
                begin
                    ctl.rd_j   = 1'b1;
                    state_next = rpb_pkg::S_CHK;
                end
            end
            rpb_pkg::S_CHK:
            begin
                if (sts.match)
                begin
                    ctl.take_j = 1'b1;
                    state_next = rpb_pkg::S_MUL;
                end
                else
                begin
                    ctl.j_inc  = 1'b1;
                    state_next = rpb_pkg::S_SCAN;
                end
            end
            rpb_pkg::S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = rpb_pkg::S_WR;
            end
            rpb_pkg::S_WR:
            begin
                ctl.wr_sec = 1'b1;
                state_next = rpb_pkg::S_NEXT_I;
            end
            rpb_pkg::S_ERD:
            begin
                ctl.emit_rd = 1'b1;
                state_next  = rpb_pkg::S_EMIT;
            end
            rpb_pkg::S_EMIT:
            begin
                ctl.emit_out = 1'b1;
                state_next   = sts.last ? rpb_pkg::S_IDLE : rpb_pkg::S_ERD;
            end
            default: state_next = rpb_pkg::S_IDLE;
        endcase
    end

    assign busy = (state_reg != rpb_pkg::S_IDLE);

endmodule

[src/rpb_datapath.sv]
// Root stores, pairing arithmetic, section stores and result fields.
`timescale 1ns / 1ps
module rpb_datapath #(
    parameter int MAX_ROOTS = rpb_pkg::MAX_ROOTS,
    parameter int FRAC_BITS = rpb_pkg::FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rpb_pkg::ctl_t                        ctl,
    output rpb_pkg::sts_t                        sts,
    input  logic [1:0]                           cmd,
    input  logic signed [rpb_pkg::ROOT_W-1:0]    root_re,
    input  logic signed [rpb_pkg::ROOT_W-1:0]    root_im,
    input  logic                                 tol_we,
    input  logic [rpb_pkg::TOL_BITS-1:0]         tol_data,
    output logic [rpb_pkg::IDX_W-1:0]            section_index,
    output logic signed [rpb_pkg::COEF_W-1:0]    zero_b1,
    output logic signed [rpb_pkg::COEF_W-1:0]    zero_b2,
    output logic signed [rpb_pkg::COEF_W-1:0]    pole_a1,
    output logic signed [rpb_pkg::COEF_W-1:0]    pole_a2,
    output logic                                 unpaired_zero,
    output logic                                 unpaired_pole,
    output logic                                 load_overflow
);

    localparam int AW  = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
    localparam int CW  = $clog2(MAX_ROOTS + 1);
    localparam int RW  = rpb_pkg::ROOT_W;
    localparam int TW  = rpb_pkg::TOL_BITS;
    localparam int CFW = rpb_pkg::COEF_W;
    localparam int PW  = 2 * RW;
    localparam int SW  = 2 * CFW;
    localparam logic signed [PW:0] RND   = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW:0] S_MAX = (PW+1)'(32'h7FFF_FFFF);
    localparam logic signed [PW:0] S_MIN = -S_MAX - (PW+1)'(1);

    logic [2*RW-1:0] zmem [MAX_ROOTS];
    logic [2*RW-1:0] pmem [MAX_ROOTS];
    logic [SW-1:0]   zsec [MAX_ROOTS];
    logic [SW-1:0]   psec [MAX_ROOTS];

    logic [2*RW-1:0] zrd_reg, prd_reg;
    logic [SW-1:0]   zsrd_reg, psrd_reg;
    logic [TW-1:0]   tol_reg;
    logic [CW-1:0]   zero_total_reg, pole_total_reg;
    logic [CW-1:0]   i_reg, j_reg, cnt_reg, nz_reg, np_reg, k_reg;
    logic [MAX_ROOTS-1:0] taken_reg;
    logic            set_reg, dz_reg, dp_reg, ovf_reg;
    logic signed [RW-1:0] r_reg, q_reg, b_reg;
    logic [TW+RW-1:0]     tolr_reg, tolq_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    logic [CW-1:0]        total_sel, ns;
    logic [2*RW-1:0]      rd_data;
    logic signed [RW-1:0] re2, im2;
    logic [AW-1:0]        rd_addr;
    logic [RW-1:0]        abs_r, abs_q;
    logic signed [RW:0]   dr, di;
    logic [RW:0]          abs_dr, abs_di;
    logic                 conj;
    logic signed [RW+1:0] lin;
    logic signed [PW:0]   psum, pshift;
    logic signed [CFW-1:0] c1, c2;

    assign total_sel = set_reg ? pole_total_reg : zero_total_reg;
    assign rd_data   = set_reg ? prd_reg : zrd_reg;
    assign re2       = rd_data[2*RW-1:RW];
    assign im2       = rd_data[RW-1:0];
    assign rd_addr   = ctl.take_i ? i_reg[AW-1:0] : j_reg[AW-1:0];

    assign abs_r  = r_reg[RW-1] ? -r_reg : r_reg;
    assign abs_q  = q_reg[RW-1] ? -q_reg : q_reg;
    assign dr     = {re2[RW-1], re2} - {r_reg[RW-1], r_reg};
    assign di     = {im2[RW-1], im2} + {q_reg[RW-1], q_reg};
    assign abs_dr = dr[RW] ? -dr : dr;
    assign abs_di = di[RW] ? -di : di;
    assign conj   = ({abs_dr, {TW{1'b0}}} <= {1'b0, tolr_reg})
                 && ({abs_di, {TW{1'b0}}} <= {1'b0, tolq_reg});

    // section coefficients: -(r+b) and rounded, saturated (p1+p2) >> FRAC_BITS
    assign lin    = -({{2{r_reg[RW-1]}}, r_reg} + {{2{b_reg[RW-1]}}, b_reg});
    assign psum   = {p1_reg[PW-1], p1_reg} + {p2_reg[PW-1], p2_reg} + RND;
    assign pshift = psum >>> FRAC_BITS;
    assign c1     = CFW'(lin);
    assign c2     = (pshift > S_MAX) ? CFW'(S_MAX) :
                    (pshift < S_MIN) ? CFW'(S_MIN) : CFW'(pshift);

    assign ns = (nz_reg > np_reg) ? nz_reg : np_reg;

    assign sts.i_end    = (i_reg >= total_sel);
    assign sts.i_taken  = taken_reg[i_reg[AW-1:0]];
    assign sts.j_end    = (j_reg >= total_sel);
    assign sts.j_taken  = taken_reg[j_reg[AW-1:0]];
    assign sts.q_nz     = (q_reg != '0);
    assign sts.match    = (q_reg != '0) ? conj : (im2 == '0);
    assign sts.set_pole = set_reg;
    assign sts.last     = ({1'b0, k_reg} + (CW+1)'(1)) >= {1'b0, ns};

    always_ff @(posedge clk)
    begin
        if (ctl.load && (rpb_pkg::cmd_t'(cmd) == rpb_pkg::CMD_LOAD_ZERO)
            && (zero_total_reg < CW'(MAX_ROOTS)))
        begin
            zmem[zero_total_reg[AW-1:0]] <= {root_re, root_im};
        end
        if (ctl.load && (rpb_pkg::cmd_t'(cmd) == rpb_pkg::CMD_LOAD_POLE)
            && (pole_total_reg < CW'(MAX_ROOTS)))
        begin
            pmem[pole_total_reg[AW-1:0]] <= {root_re, root_im};
        end
        zrd_reg <= zmem[rd_addr];
        prd_reg <= pmem[rd_addr];
        if (ctl.wr_sec && !set_reg)
        begin
            zsec[cnt_reg[AW-1:0]] <= {c1, c2};
        end
        if (ctl.wr_sec && set_reg)
        begin
            psec[cnt_reg[AW-1:0]] <= {c1, c2};
        end
        if (ctl.emit_rd)
        begin
            zsrd_reg <= zsec[k_reg[AW-1:0]];
            psrd_reg <= psec[k_reg[AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_i)
        begin
            r_reg <= re2;
            q_reg <= im2;
        end
        if (ctl.tol)
        begin
            tolr_reg <= tol_reg * abs_r;
            tolq_reg <= tol_reg * abs_q;
        end
        if (ctl.take_j)
        begin
            b_reg <= (q_reg != '0) ? r_reg : re2;
        end
        else if (ctl.alone)
        begin
            b_reg <= '0;
        end
        if (ctl.mul)
        begin
            p1_reg <= r_reg * b_reg;
            p2_reg <= q_reg * q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg        <= rpb_pkg::TOL_RESET;
            zero_total_reg <= '0;
            pole_total_reg <= '0;
            taken_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            cnt_reg        <= '0;
            nz_reg         <= '0;
            np_reg         <= '0;
            k_reg          <= '0;
            set_reg        <= 1'b0;
            dz_reg         <= 1'b0;
            dp_reg         <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (tol_we)
            begin
                tol_reg <= tol_data;
            end
            if (ctl.load)
            begin
                if (rpb_pkg::cmd_t'(cmd) == rpb_pkg::CMD_LOAD_ZERO)
                begin
                    if (zero_total_reg < CW'(MAX_ROOTS))
                        zero_total_reg <= zero_total_reg + CW'(1);
                    else
                        ovf_reg <= 1'b1;
                end
                else
                begin
                    if (pole_total_reg < CW'(MAX_ROOTS))
                        pole_total_reg <= pole_total_reg + CW'(1);
                    else
                        ovf_reg <= 1'b1;
                end
            end
            if (ctl.clear)
            begin
                zero_total_reg <= '0;
                pole_total_reg <= '0;
                taken_reg      <= '0;
                dz_reg         <= 1'b0;
                dp_reg         <= 1'b0;
                ovf_reg        <= 1'b0;
            end
            if (ctl.start)
            begin
                set_reg   <= 1'b0;
                i_reg     <= '0;
                cnt_reg   <= '0;
                taken_reg <= '0;
                dz_reg    <= 1'b0;
                dp_reg    <= 1'b0;
            end
            if (ctl.next_set)
            begin
                nz_reg    <= cnt_reg;
                set_reg   <= 1'b1;
                i_reg     <= '0;
                cnt_reg   <= '0;
                taken_reg <= '0;
            end
            if (ctl.finish)
            begin
                np_reg <= cnt_reg;
                k_reg  <= '0;
            end
            if (ctl.take_i)
            begin
                taken_reg[i_reg[AW-1:0]] <= 1'b1;
            end
            if (ctl.latch_i)
            begin
                j_reg <= i_reg + CW'(1);
            end
            if (ctl.j_inc)
            begin
                j_reg <= j_reg + CW'(1);
            end
            if (ctl.take_j)
            begin
                taken_reg[j_reg[AW-1:0]] <= 1'b1;
            end
            if (ctl.i_inc)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (ctl.drop)
            begin
                if (set_reg)
                    dp_reg <= 1'b1;
                else
                    dz_reg <= 1'b1;
            end
            if (ctl.wr_sec)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                i_reg   <= i_reg + CW'(1);
            end
            if (ctl.emit_out)
            begin
                k_reg <= k_reg + CW'(1);
            end
        end
    end

    assign section_index = rpb_pkg::IDX_W'(k_reg);
    assign zero_b1       = (k_reg < nz_reg) ? zsrd_reg[SW-1:CFW] : '0;
    assign zero_b2       = (k_reg < nz_reg) ? zsrd_reg[CFW-1:0]  : '0;
    assign pole_a1       = (k_reg < np_reg) ? psrd_reg[SW-1:CFW] : '0;
    assign pole_a2       = (k_reg < np_reg) ? psrd_reg[CFW-1:0]  : '0;
    assign unpaired_zero = dz_reg;
    assign unpaired_pole = dp_reg;
    assign load_overflow = ovf_reg;

endmodule

[src/root_pairing_biquad_sections.sv]
// Top level: zero/pole pairing into second-order sections.
`timescale 1ns / 1ps
// Loads (cmd 0 and 1), clear (cmd 3) and register writes leave busy low. A
// compute (cmd 2) holds busy high while a sequencer walks the zero store and
// then the pole store through one registered read port: each unused root is
// fetched, latched and has its tolerance scaled, each later candidate is
// skipped if taken or else read and checked, and each section formed is
// multiplied and then written. Sections then come out on section_valid, one
// beat each, last marking the final one; the receiver cannot stall them, so
// it must take every beat.
module root_pairing_biquad_sections #(
    parameter int MAX_ROOTS = rpb_pkg::MAX_ROOTS,
    parameter int FRAC_BITS = rpb_pkg::FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        cmd,
    input  logic signed [rpb_pkg::ROOT_W-1:0] root_re,
    input  logic signed [rpb_pkg::ROOT_W-1:0] root_im,
    input  logic                              match_tolerance_we,
    input  logic [rpb_pkg::TOL_BITS-1:0]      match_tolerance,
    output logic                              section_valid,
    output logic [rpb_pkg::IDX_W-1:0]         section_index,
    output logic signed [rpb_pkg::COEF_W-1:0] zero_b1,
    output logic signed [rpb_pkg::COEF_W-1:0] zero_b2,
    output logic signed [rpb_pkg::COEF_W-1:0] pole_a1,
    output logic signed [rpb_pkg::COEF_W-1:0] pole_a2,
    output logic                              unpaired_zero,
    output logic                              unpaired_pole,
    output logic                              load_overflow,
    output logic                              last
);

    rpb_pkg::ctl_t ctl;
    rpb_pkg::sts_t sts;

    rpb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    rpb_datapath #(
        .MAX_ROOTS (MAX_ROOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (cmd),
        .root_re       (root_re),
        .root_im       (root_im),
        .tol_we        (match_tolerance_we),
        .tol_data      (match_tolerance),
        .section_index (section_index),
        .zero_b1       (zero_b1),
        .zero_b2       (zero_b2),
        .pole_a1       (pole_a1),
        .pole_a2       (pole_a2),
        .unpaired_zero (unpaired_zero),
        .unpaired_pole (unpaired_pole),
        .load_overflow (load_overflow)
    );

    assign section_valid = ctl.emit_out;
    assign last          = ctl.emit_out && sts.last;

    a_beat_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        section_valid |-> busy)
        else $error("section beat outside a compute");

    a_compute_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == rpb_pkg::CMD_COMPUTE)) |=> busy)
        else $error("compute not started");

    a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
        last |=> !busy && !section_valid)
        else $error("beats after last section");

    a_beats_apart : assert property (@(posedge clk) disable iff (!rst_n)
        section_valid |=> !section_valid)
        else $error("section beats back to back");

endmodule
